// ===== rtl/ctl_pkg.sv =====
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared token kinds, error codes and item types for the configuration text
// lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctl_pkg;

	localparam int WS_HOLD_DEPTH_DEF = 16;

	// Token kinds.
	localparam logic [4:0] KIND_LITERAL = 5'd0;
	localparam logic [4:0] KIND_GROUP   = 5'd1;
	localparam logic [4:0] KIND_STRING  = 5'd2;
	localparam logic [4:0] KIND_VALUE   = 5'd3;
	localparam logic [4:0] KIND_ASSIGN  = 5'd4;
	localparam logic [4:0] KIND_EQ      = 5'd5;
	localparam logic [4:0] KIND_NE      = 5'd6;
	localparam logic [4:0] KIND_LT      = 5'd7;
	localparam logic [4:0] KIND_GT      = 5'd8;
	localparam logic [4:0] KIND_LE      = 5'd9;
	localparam logic [4:0] KIND_GE      = 5'd10;
	localparam logic [4:0] KIND_NOT     = 5'd11;
	localparam logic [4:0] KIND_AND     = 5'd12;
	localparam logic [4:0] KIND_OR      = 5'd13;
	localparam logic [4:0] KIND_LBRACE  = 5'd14;
	localparam logic [4:0] KIND_RBRACE  = 5'd15;
	localparam logic [4:0] KIND_LPAREN  = 5'd16;
	localparam logic [4:0] KIND_RPAREN  = 5'd17;
	localparam logic [4:0] KIND_INCLUDE = 5'd18;
	localparam logic [4:0] KIND_IF      = 5'd19;
	localparam logic [4:0] KIND_ELSE    = 5'd20;
	localparam logic [4:0] KIND_EOF     = 5'd21;
	localparam logic [4:0] KIND_ERROR   = 5'd22;

	// Error codes.
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_UNEXPECTED  = 3'd1;
	localparam logic [2:0] ERR_EOF_GROUP   = 3'd2;
	localparam logic [2:0] ERR_EOF_STRING  = 3'd3;
	localparam logic [2:0] ERR_WS_OVERFLOW = 3'd4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef struct packed {
		logic [4:0]  kind;
		logic [7:0]  text_byte;
		logic        has_text;
		logic        token_end;
		logic [2:0]  error_code;
		logic [15:0] line;
	} item_t;

	// Up to three ordinary result items of one input transaction.
	typedef struct packed {
		item_t [2:0] item;
		logic [1:0]  n;
	} step_res_t;

endpackage

`default_nettype wire

// ===== rtl/ctl_scan.sv =====
// ----------------------------------------------------------------------------
// ctl_scan
// Scanner state and the per-character step logic. On each step strobe it
// consumes one character or end-of-file mark, updates its state and returns
// the ordinary result items plus the number of held blanks to emit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctl_scan #(
	parameter int WS_HOLD_DEPTH = ctl_pkg::WS_HOLD_DEPTH_DEF,
	localparam int CW = $clog2(WS_HOLD_DEPTH + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  wire                   req_eof,
	input  wire [7:0]             in_byte,
	output ctl_pkg::step_res_t    res,
	output logic [CW-1:0]         flush_n,
	input  wire                   hs_pop,
	output logic                  hs_head
);

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_COMMENT = 4'd1,
		M_GROUP   = 4'd2,
		M_STRING  = 4'd3,
		M_STRESC  = 4'd4,
		M_OPHELD  = 4'd5,
		M_LITERAL = 4'd6,
		M_LITWS   = 4'd7,
		M_LITEQ   = 4'd8,
		M_VALLEAD = 4'd9,
		M_VALUE   = 4'd10,
		M_DEAD    = 4'd11
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  op;
		logic [3:0]  kw;
		logic [15:0] lc;
		logic [15:0] tl;
	} st_t;

	typedef struct packed {
		st_t             s;
		logic            v;
		ctl_pkg::item_t  it;
	} tok_res_t;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_ASSIGN = 3'd1;
	localparam logic [2:0] OP_NOT    = 3'd2;
	localparam logic [2:0] OP_LT     = 3'd3;
	localparam logic [2:0] OP_GT     = 3'd4;
	localparam logic [2:0] OP_AND    = 3'd5;
	localparam logic [2:0] OP_OR     = 3'd6;

	localparam logic [3:0] KW_NONE    = 4'd0;
	localparam logic [3:0] KW_I       = 4'd2;
	localparam logic [3:0] KW_IF      = 4'd3;
	localparam logic [3:0] KW_IN      = 4'd4;
	localparam logic [3:0] KW_INC     = 4'd5;
	localparam logic [3:0] KW_INCL    = 4'd6;
	localparam logic [3:0] KW_INCLU   = 4'd7;
	localparam logic [3:0] KW_INCLUD  = 4'd8;
	localparam logic [3:0] KW_INCLUDE = 4'd9;
	localparam logic [3:0] KW_E       = 4'd10;
	localparam logic [3:0] KW_EL      = 4'd11;
	localparam logic [3:0] KW_ELS     = 4'd12;
	localparam logic [3:0] KW_ELSE    = 4'd13;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	st_t                     st_q, st_d;
	logic [CW-1:0]           hsc_q, hsc_d;
	logic                    push_en;
	logic                    push_bit;
	logic [WS_HOLD_DEPTH-1:0] hs_q;

	function automatic logic is_lit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
		       (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER || c == CH_DOT;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == ctl_pkg::CH_SPACE || c == ctl_pkg::CH_TAB;
	endfunction

	function automatic logic [7:0] op_char(input logic [2:0] op);
		logic [7:0] r;
		case (op)
			OP_ASSIGN: r = CH_EQ;
			OP_NOT:    r = CH_BANG;
			OP_LT:     r = CH_LT;
			OP_GT:     r = CH_GT;
			OP_AND:    r = CH_AMP;
			OP_OR:     r = CH_PIPE;
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] op_single(input logic [2:0] op);
		logic [4:0] r;
		case (op)
			OP_ASSIGN: r = ctl_pkg::KIND_ASSIGN;
			OP_NOT:    r = ctl_pkg::KIND_NOT;
			OP_LT:     r = ctl_pkg::KIND_LT;
			OP_GT:     r = ctl_pkg::KIND_GT;
			default:   r = ctl_pkg::KIND_LITERAL;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] op_double(input logic [2:0] op);
		logic [4:0] r;
		case (op)
			OP_ASSIGN: r = ctl_pkg::KIND_EQ;
			OP_NOT:    r = ctl_pkg::KIND_NE;
			OP_LT:     r = ctl_pkg::KIND_LE;
			OP_GT:     r = ctl_pkg::KIND_GE;
			OP_AND:    r = ctl_pkg::KIND_AND;
			OP_OR:     r = ctl_pkg::KIND_OR;
			default:   r = ctl_pkg::KIND_LITERAL;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] op_of(input logic [7:0] c);
		logic [2:0] r;
		case (c)
			CH_EQ:   r = OP_ASSIGN;
			CH_BANG: r = OP_NOT;
			CH_LT:   r = OP_LT;
			CH_GT:   r = OP_GT;
			CH_AMP:  r = OP_AND;
			CH_PIPE: r = OP_OR;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	// Tracks a literal against the prefixes of if, include and else.
	function automatic logic [3:0] kw_next(input logic [3:0] s, input logic [7:0] c);
		logic [3:0] r;
		r = KW_NONE;
		case (s)
			KW_I:      r = (c == 8'h66) ? KW_IF : ((c == 8'h6E) ? KW_IN : KW_NONE);
			KW_IN:     r = (c == 8'h63) ? KW_INC : KW_NONE;
			KW_INC:    r = (c == 8'h6C) ? KW_INCL : KW_NONE;
			KW_INCL:   r = (c == 8'h75) ? KW_INCLU : KW_NONE;
			KW_INCLU:  r = (c == 8'h64) ? KW_INCLUD : KW_NONE;
			KW_INCLUD: r = (c == 8'h65) ? KW_INCLUDE : KW_NONE;
			KW_E:      r = (c == 8'h6C) ? KW_EL : KW_NONE;
			KW_EL:     r = (c == 8'h73) ? KW_ELS : KW_NONE;
			KW_ELS:    r = (c == 8'h65) ? KW_ELSE : KW_NONE;
			default:   r = KW_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] kw_kind(input logic [3:0] s);
		logic [4:0] r;
		case (s)
			KW_INCLUDE: r = ctl_pkg::KIND_INCLUDE;
			KW_IF:      r = ctl_pkg::KIND_IF;
			KW_ELSE:    r = ctl_pkg::KIND_ELSE;
			default:    r = ctl_pkg::KIND_LITERAL;
		endcase
		return r;
	endfunction

	function automatic ctl_pkg::item_t mk(input logic [4:0] kind, input logic [7:0] txt,
			input logic has, input logic fin, input logic [2:0] err,
			input logic [15:0] line);
		ctl_pkg::item_t it;
		it.kind       = kind;
		it.text_byte  = txt;
		it.has_text   = has;
		it.token_end  = fin;
		it.error_code = err;
		it.line       = line;
		return it;
	endfunction

	function automatic ctl_pkg::step_res_t add(input ctl_pkg::step_res_t r,
			input ctl_pkg::item_t it);
		ctl_pkg::step_res_t o;
		o = r;
		o.item[r.n] = it;
		o.n = r.n + 2'd1;
		return o;
	endfunction

	function automatic st_t next_line(input st_t s);
		st_t o;
		o = s;
		if (s.lc != 16'hFFFF)
			o.lc = s.lc + 16'd1;
		return o;
	endfunction

	// Starts a new token from the idle state; emits at most one item.
	function automatic tok_res_t start_tok(input st_t s_in, input logic [7:0] c);
		tok_res_t t;
		logic [2:0] op;
		t    = '0;
		t.s  = s_in;
		t.s.tl = s_in.lc;
		op   = op_of(c);
		if (c == CH_SEMI || c == CH_HASH) begin
			t.s.mode = M_COMMENT;
		end else if (is_blank(c)) begin
			t.v = 1'b0;
		end else if (c == CH_NL) begin
			t.s = next_line(t.s);
		end else if (c == CH_LBRK) begin
			t.s.mode = M_GROUP;
		end else if (c == CH_QUOTE) begin
			t.s.mode = M_STRING;
		end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN) begin
			t.v = 1'b1;
			t.it = mk((c == CH_LBRACE) ? ctl_pkg::KIND_LBRACE :
			          (c == CH_RBRACE) ? ctl_pkg::KIND_RBRACE :
			          (c == CH_LPAREN) ? ctl_pkg::KIND_LPAREN : ctl_pkg::KIND_RPAREN,
			          8'h00, 1'b0, 1'b1, ctl_pkg::ERR_NONE, t.s.tl);
		end else if (op != OP_NONE) begin
			t.s.op   = op;
			t.s.mode = M_OPHELD;
		end else if (is_lit(c)) begin
			t.s.kw   = (c == 8'h69) ? KW_I : ((c == 8'h65) ? KW_E : KW_NONE);
			t.s.mode = M_LITERAL;
			t.v  = 1'b1;
			t.it = mk(ctl_pkg::KIND_LITERAL, c, 1'b1, 1'b0, ctl_pkg::ERR_NONE, t.s.tl);
		end else begin
			t.v  = 1'b1;
			t.it = mk(ctl_pkg::KIND_ERROR, c, 1'b0, 1'b1, ctl_pkg::ERR_UNEXPECTED, t.s.tl);
			t.s.mode = M_DEAD;
		end
		return t;
	endfunction

	always_comb begin
		st_t                s;
		ctl_pkg::step_res_t r;
		tok_res_t           t;
		logic [7:0]         c;
		logic [2:0]         op;
		logic [CW-1:0]      fl;
		s        = st_q;
		r        = '0;
		t        = '0;
		c        = in_byte;
		op       = (st_q.op <= OP_OR) ? st_q.op : OP_NONE;
		fl       = '0;
		hsc_d    = hsc_q;
		push_en  = 1'b0;
		push_bit = 1'b0;
		if (req_eof) begin
			case (s.mode)
				M_GROUP: r = add(r, mk(ctl_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
				                       ctl_pkg::ERR_EOF_GROUP, s.tl));
				M_STRING: r = add(r, mk(ctl_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
				                        ctl_pkg::ERR_EOF_STRING, s.tl));
				M_STRESC: r = add(r, mk(ctl_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
				                        ctl_pkg::ERR_NONE, s.tl));
				M_OPHELD: begin
					if (op == OP_AND || op == OP_OR)
						r = add(r, mk(ctl_pkg::KIND_ERROR, op_char(op), 1'b0, 1'b1,
						              ctl_pkg::ERR_UNEXPECTED, s.tl));
					else if (op != OP_NONE)
						r = add(r, mk(op_single(op), 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
				end
				M_LITERAL: r = add(r, mk(kw_kind(s.kw), 8'h00, 1'b0, 1'b1,
				                         ctl_pkg::ERR_NONE, s.tl));
				M_LITEQ: begin
					r = add(r, mk(ctl_pkg::KIND_ASSIGN, 8'h00, 1'b0, 1'b1,
					              ctl_pkg::ERR_NONE, s.tl));
					r = add(r, mk(ctl_pkg::KIND_VALUE, 8'h00, 1'b0, 1'b1,
					              ctl_pkg::ERR_NONE, s.tl));
				end
				M_VALLEAD, M_VALUE: r = add(r, mk(ctl_pkg::KIND_VALUE, 8'h00, 1'b0, 1'b1,
				                                  ctl_pkg::ERR_NONE, s.tl));
				default: ;
			endcase
			r = add(r, mk(ctl_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, ctl_pkg::ERR_NONE, s.lc));
			// Back to the reset state for the next file.
			s     = '0;
			hsc_d = '0;
		end else begin
			case (s.mode)
				M_IDLE: begin
					t = start_tok(s, c);
					s = t.s;
					if (t.v)
						r = add(r, t.it);
				end
				M_COMMENT: begin
					if (c == CH_NL) begin
						s = next_line(s);
						s.mode = M_IDLE;
					end
				end
				M_GROUP: begin
					if (c == CH_RBRK) begin
						r = add(r, mk(ctl_pkg::KIND_GROUP, 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
						s.mode = M_IDLE;
					end else begin
						r = add(r, mk(ctl_pkg::KIND_GROUP, c, 1'b1, 1'b0,
						              ctl_pkg::ERR_NONE, s.tl));
						if (c == CH_NL)
							s = next_line(s);
					end
				end
				M_STRING: begin
					if (c == CH_BSLASH) begin
						s.mode = M_STRESC;
					end else if (c == CH_QUOTE) begin
						r = add(r, mk(ctl_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
						s.mode = M_IDLE;
					end else begin
						r = add(r, mk(ctl_pkg::KIND_STRING, c, 1'b1, 1'b0,
						              ctl_pkg::ERR_NONE, s.tl));
						if (c == CH_NL)
							s = next_line(s);
					end
				end
				M_STRESC: begin
					if (c == CH_QUOTE) begin
						r = add(r, mk(ctl_pkg::KIND_STRING, c, 1'b1, 1'b0,
						              ctl_pkg::ERR_NONE, s.tl));
						s.mode = M_STRING;
					end else begin
						// The backslash is dropped and the byte starts a new token.
						r = add(r, mk(ctl_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
						s.mode = M_IDLE;
						t = start_tok(s, c);
						s = t.s;
						if (t.v)
							r = add(r, t.it);
					end
				end
				M_OPHELD: begin
					s.op = OP_NONE;
					if (op == OP_NONE) begin
						s.mode = M_IDLE;
						t = start_tok(s, c);
						s = t.s;
						if (t.v)
							r = add(r, t.it);
					end else if (c == ((op >= OP_AND) ? op_char(op) : CH_EQ)) begin
						r = add(r, mk(op_double(op), 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
						s.mode = M_IDLE;
					end else if (op >= OP_AND) begin
						r = add(r, mk(ctl_pkg::KIND_ERROR, op_char(op), 1'b0, 1'b1,
						              ctl_pkg::ERR_UNEXPECTED, s.tl));
						s.mode = M_DEAD;
					end else begin
						r = add(r, mk(op_single(op), 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
						s.mode = M_IDLE;
						t = start_tok(s, c);
						s = t.s;
						if (t.v)
							r = add(r, t.it);
					end
				end
				M_LITERAL, M_LITWS: begin
					if (s.mode == M_LITERAL && is_lit(c)) begin
						s.kw = kw_next(s.kw, c);
						r = add(r, mk(ctl_pkg::KIND_LITERAL, c, 1'b1, 1'b0,
						              ctl_pkg::ERR_NONE, s.tl));
					end else begin
						if (s.mode == M_LITERAL) begin
							r = add(r, mk(kw_kind(s.kw), 8'h00, 1'b0, 1'b1,
							              ctl_pkg::ERR_NONE, s.tl));
							s.kw   = KW_NONE;
							s.mode = M_LITWS;
						end
						if (c == CH_EQ) begin
							s.mode = M_LITEQ;
						end else if (!is_blank(c)) begin
							s.mode = M_IDLE;
							t = start_tok(s, c);
							s = t.s;
							if (t.v)
								r = add(r, t.it);
						end
					end
				end
				M_LITEQ, M_VALLEAD: begin
					if (s.mode == M_LITEQ && c == CH_EQ) begin
						r = add(r, mk(ctl_pkg::KIND_EQ, 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
						s.mode = M_IDLE;
					end else begin
						if (s.mode == M_LITEQ) begin
							r = add(r, mk(ctl_pkg::KIND_ASSIGN, 8'h00, 1'b0, 1'b1,
							              ctl_pkg::ERR_NONE, s.tl));
							s.mode = M_VALLEAD;
						end
						if (c == CH_NL) begin
							r = add(r, mk(ctl_pkg::KIND_VALUE, 8'h00, 1'b0, 1'b1,
							              ctl_pkg::ERR_NONE, s.tl));
							s.mode = M_IDLE;
							s = next_line(s);
						end else if (!is_blank(c)) begin
							hsc_d  = '0;
							s.mode = M_VALUE;
							r = add(r, mk(ctl_pkg::KIND_VALUE, c, 1'b1, 1'b0,
							              ctl_pkg::ERR_NONE, s.tl));
						end
					end
				end
				M_VALUE: begin
					if (c == CH_NL) begin
						r = add(r, mk(ctl_pkg::KIND_VALUE, 8'h00, 1'b0, 1'b1,
						              ctl_pkg::ERR_NONE, s.tl));
						hsc_d  = '0;
						s.mode = M_IDLE;
						s = next_line(s);
					end else if (is_blank(c)) begin
						if (hsc_q >= CW'(WS_HOLD_DEPTH)) begin
							hsc_d = '0;
							r = add(r, mk(ctl_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
							              ctl_pkg::ERR_WS_OVERFLOW, s.tl));
							s.mode = M_DEAD;
						end else begin
							push_en  = 1'b1;
							push_bit = (c == ctl_pkg::CH_TAB);
							hsc_d    = hsc_q + CW'(1);
						end
					end else begin
						// Held blanks go out ahead of this character.
						fl    = hsc_q;
						hsc_d = '0;
						r = add(r, mk(ctl_pkg::KIND_VALUE, c, 1'b1, 1'b0,
						              ctl_pkg::ERR_NONE, s.tl));
					end
				end
				default: begin
					if (c == CH_NL)
						s = next_line(s);
				end
			endcase
		end
		st_d    = s;
		res     = r;
		flush_n = fl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			hsc_q <= '0;
		end else if (step) begin
			st_q  <= st_d;
			hsc_q <= hsc_d;
		end
	end

	// Held blank kinds (1 = tab), drained from bit 0 while they are emitted.
	always_ff @(posedge clk) begin
		if (hs_pop) begin
			hs_q <= hs_q >> 1;
		end else if (step && push_en) begin
			for (int i = 0; i < WS_HOLD_DEPTH; i++) begin
				if (hsc_q == CW'(i))
					hs_q[i] <= push_bit;
			end
		end
	end

	assign hs_head = hs_q[0];

endmodule

`default_nettype wire

// ===== rtl/config_text_lexer.sv =====
// ----------------------------------------------------------------------------
// config_text_lexer
// Streaming tokenizer for configuration text.
//
// The slave channel takes one transaction per character: s_tdata holds the
// byte and s_tuser set marks end of file (s_tdata is then ignored). The master
// channel gives token items: text tokens give one item per character and a
// closing item, fixed tokens a closing item only. m_tlast marks the last item
// caused by one input transaction; many characters cause no item at all.
// An accepted character is held in an input register and is scanned once the
// result buffer is free; its items are registered in the result buffer and
// offered on the master side from there. Plain text runs at one character
// per cycle while m_tready stays high. A character with more items, or a value
// character that releases held blanks, holds the result buffer until the
// blanks and then its items are delivered; the input side stalls meanwhile.
// The input is taken while the last pending item is being delivered, so a
// stalled receiver blocks input only once the single input register is full.
// Reset empties both registers and returns the scanner to the start of a file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module config_text_lexer #(
	parameter int WS_HOLD_DEPTH = ctl_pkg::WS_HOLD_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	input  wire  [0:0]  s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] text_byte, [10:8] error_code, [26:11] line
	output logic [6:0]  m_tuser,   // [4:0] kind, [5] has_text, [6] token_end
	output logic        m_tlast
);

	localparam int CW = $clog2(WS_HOLD_DEPTH + 1);

	logic               in_valid_s1;
	logic               in_eof_s1;
	logic [7:0]         in_byte_s1;

	ctl_pkg::step_res_t res;
	logic [CW-1:0]      flush_n;
	logic               hs_head;
	logic               hs_pop;

	ctl_pkg::step_res_t res_q;
	logic [1:0]         pos_q;
	logic [CW-1:0]      fl_left_q;

	ctl_pkg::item_t     head;
	logic               busy;
	logic               out_last;
	logic               pop;
	logic               free;
	logic               step;

	ctl_scan #(
		.WS_HOLD_DEPTH (WS_HOLD_DEPTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.req_eof (in_eof_s1),
		.in_byte (in_byte_s1),
		.res     (res),
		.flush_n (flush_n),
		.hs_pop  (hs_pop),
		.hs_head (hs_head)
	);

	assign busy     = (fl_left_q != '0) || (pos_q != res_q.n);
	assign out_last = (fl_left_q == '0) && (2'(pos_q + 2'd1) == res_q.n);
	assign pop      = busy && m_tready;
	assign free     = !busy || (pop && out_last);
	assign step     = in_valid_s1 && free;
	assign s_tready = !in_valid_s1 || step;
	assign hs_pop   = pop && (fl_left_q != '0);

	always_comb begin
		if (fl_left_q != '0) begin
			head.kind       = ctl_pkg::KIND_VALUE;
			head.text_byte  = hs_head ? ctl_pkg::CH_TAB : ctl_pkg::CH_SPACE;
			head.has_text   = 1'b1;
			head.token_end  = 1'b0;
			head.error_code = ctl_pkg::ERR_NONE;
			head.line       = res_q.item[0].line;
		end else begin
			case (pos_q)
				2'd0:    head = res_q.item[0];
				2'd1:    head = res_q.item[1];
				2'd2:    head = res_q.item[2];
				default: head = '0;
			endcase
		end
	end

	assign m_tvalid = busy;
	assign m_tdata  = {5'd0, head.line, head.error_code, head.text_byte};
	assign m_tuser  = {head.token_end, head.has_text, head.kind};
	assign m_tlast  = out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_eof_s1  <= s_tuser[0];
			in_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q     <= '0;
			pos_q     <= '0;
			fl_left_q <= '0;
		end else if (step) begin
			res_q     <= res;
			pos_q     <= '0;
			fl_left_q <= flush_n;
		end else if (pop) begin
			if (fl_left_q != '0)
				fl_left_q <= fl_left_q - CW'(1);
			else
				pos_q <= pos_q + 2'd1;
		end
	end

endmodule

`default_nettype wire
